@@ src/ifmt_pkg.sv @@
// Shared types, codes and character helpers for the integer field formatter.
package ifmt_pkg;

  localparam logic [2:0] FN_DEC  = 3'd0;
  localparam logic [2:0] FN_UNS  = 3'd1;
  localparam logic [2:0] FN_OCT  = 3'd2;
  localparam logic [2:0] FN_HEX  = 3'd3;
  localparam logic [2:0] FN_HEXU = 3'd4;
  localparam logic [2:0] FN_PTR  = 3'd5;
  localparam logic [2:0] FN_CHR  = 3'd6;
  localparam logic [2:0] FN_PCT  = 3'd7;

  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_64 = 2'd2;

  localparam int NDIG = 22;
  localparam int DIGW = 4 * NDIG;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_CONV, ST_NORM, ST_SIZE, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {DS_NUM, DS_NIL, DS_CHR} dsrc_t;

  typedef struct packed {
    logic [6:0] pad_end;
    logic [6:0] pre_end;
    logic [6:0] zero_end;
    logic [6:0] dig_end;
    logic [6:0] total;
    logic [7:0] pre0;
    logic [7:0] pre1;
    dsrc_t      src;
    logic       upper;
    logic [7:0] chr;
  } plan_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
    logic [7:0] res;
    if (d < 4'd10) res = 8'h30 + {4'h0, d};
    else if (upper) res = 8'h37 + {4'h0, d};
    else res = 8'h57 + {4'h0, d};
    return res;
  endfunction

  function automatic logic [7:0] nil_char(input logic [2:0] i);
    logic [7:0] res;
    case (i)
      3'd0: res = 8'h28;
      3'd1: res = 8'h6e;
      3'd2: res = 8'h69;
      3'd3: res = 8'h6c;
      default: res = 8'h29;
    endcase
    return res;
  endfunction

endpackage

@@ src/integer_field_formatter_top.sv @@
// Top level of the printf-style integer field formatter.
//
// Usage: one conversion request enters on the in_ stream when in_tready is
// high; its text leaves on the out_ stream one character per word, with
// out_tlast on the final character. An empty text (precision zero, value
// zero, width zero) gives no word at all.
// Steps: the request is registered, the digits are prepared, bit-serial BCD
// conversion runs for decimal conversions only, up to 21 leading zero
// digits are stripped (one digit a cycle), the field is sized, then one
// character per cycle while the receiver is ready, up to 62 characters.
// Hex and octal skip the conversion; a character or percent skips both the
// conversion and the stripping.
// One request is worked on at a time; in_tready is high only when idle.
// The next request may be taken while the last character still waits in
// the output register. A stalled receiver holds the output word and the
// character sequencer waits; nothing is dropped.
// Reset (rst_n low, synchronous) returns to idle and empties the output.
module integer_field_formatter_top #(
  parameter int MAX_FIELD = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // [63:0] value, [65:64] size_mod, [66] left_align,
                                  // [67] force_sign, [68] space_sign, [69] alt_form,
                                  // [70] zero_pad, [76:71] field_width,
                                  // [77] prec_given, [83:78] prec_digits, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_char
  output logic        out_tlast
);
  import ifmt_pkg::*;

  state_t          state_r, state_nxt;
  logic [2:0]      func_r, func_nxt;
  logic [63:0]     mag_r, mag_nxt;
  logic            neg_r, neg_nxt;
  logic            left_r, plus_r, space_r, alt_r, zflag_r, pg_r;
  logic [5:0]      width_r, prec_r;
  logic [7:0]      chr_r;
  logic [DIGW-1:0] digs_r, digs_nxt;
  logic [4:0]      dl_r, dl_nxt;
  logic            accept;

  // raw fields
  logic [63:0] f_value;
  logic [1:0]  f_size;
  logic [5:0]  f_width, f_prec;
  logic [63:0] cut;

  logic        dab_start, dab_busy;
  logic [DIGW-1:0] dab_bcd;
  logic        emit_start, emit_busy, dig_shift;
  plan_t       plan;
  logic [65:0] m66;

  assign f_value = in_tdata[63:0];
  assign f_size  = in_tdata[65:64];
  assign f_width = in_tdata[76:71];
  assign f_prec  = in_tdata[83:78];

  assign in_tready = state_r == ST_IDLE;
  assign accept    = in_tvalid && in_tready;

  // cut the value to the size modifier (pointers keep all 64 bits), sign-extend for signed decimal
  always_comb begin
    if (in_tuser == FN_PTR || f_size == SZ_64) begin
      cut = f_value;
    end else if (f_size == SZ_16) begin
      cut = {{48{(in_tuser == FN_DEC) && f_value[15]}}, f_value[15:0]};
    end else begin
      cut = {{32{(in_tuser == FN_DEC) && f_value[31]}}, f_value[31:0]};
    end
  end

  assign m66 = {2'b00, mag_r};

  // field sizing
  logic       is_num, mag_zero, ptr_nil, use_prec, empty, zmode;
  logic [6:0] dl_eff, zeros, plen, body, pad, zeros_f, pad_f, width7, prec7;
  logic [7:0] p0, p1;

  always_comb begin
    is_num   = func_r <= FN_PTR;
    mag_zero = mag_r == 64'd0;
    ptr_nil  = (func_r == FN_PTR) && mag_zero;
    use_prec = is_num && (func_r != FN_PTR);
    width7   = {1'b0, width_r};
    prec7    = {1'b0, prec_r};
    empty    = use_prec && pg_r && (prec_r == 6'd0) && mag_zero;
    if (!is_num) dl_eff = 7'd1;
    else if (ptr_nil) dl_eff = 7'd5;
    else if (empty) dl_eff = 7'd0;
    else dl_eff = {2'b00, dl_r};
    zeros = (use_prec && pg_r && (prec7 > dl_eff)) ? prec7 - dl_eff : 7'd0;
    p0 = 8'h30;
    p1 = 8'h78;
    plen = 7'd0;
    case (func_r)
      FN_DEC: begin
        if (neg_r) begin
          p0 = 8'h2d; plen = 7'd1;
        end else if (plus_r) begin
          p0 = 8'h2b; plen = 7'd1;
        end else if (space_r) begin
          p0 = 8'h20; plen = 7'd1;
        end
      end
      FN_PTR: if (!mag_zero) plen = 7'd2;
      FN_OCT: if (alt_r && (zeros == 7'd0) && ((dl_eff == 7'd0) || !mag_zero)) plen = 7'd1;
      FN_HEX, FN_HEXU: begin
        if (alt_r && !mag_zero) plen = 7'd2;
        if (func_r == FN_HEXU) p1 = 8'h58;
      end
      default: plen = 7'd0;
    endcase
    zmode = zflag_r && !left_r && !pg_r && !ptr_nil;
    body  = plen + zeros + dl_eff;
    pad   = (width7 > body) ? width7 - body : 7'd0;
    zeros_f = zmode ? zeros + pad : zeros;
    pad_f   = zmode ? 7'd0 : pad;
    plan.pad_end  = left_r ? 7'd0 : pad_f;
    plan.pre_end  = plan.pad_end + plen;
    plan.zero_end = plan.pre_end + zeros_f;
    plan.dig_end  = plan.zero_end + dl_eff;
    plan.total    = plan.dig_end + (left_r ? pad_f : 7'd0);
    plan.pre0     = p0;
    plan.pre1     = p1;
    plan.src      = !is_num ? DS_CHR : (ptr_nil ? DS_NIL : DS_NUM);
    plan.upper    = func_r == FN_HEXU;
    plan.chr      = chr_r;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    func_nxt   = func_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    digs_nxt   = digs_r;
    dl_nxt     = dl_r;
    dab_start  = 1'b0;
    emit_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = in_tuser;
          neg_nxt   = (in_tuser == FN_DEC) && cut[63];
          mag_nxt   = ((in_tuser == FN_DEC) && cut[63]) ? 64'd0 - cut : cut;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        dl_nxt = 5'(NDIG);
        if (func_r == FN_DEC || func_r == FN_UNS) begin
          dab_start = 1'b1;
          state_nxt = ST_CONV;
        end else if (func_r == FN_OCT) begin
          for (int k = 0; k < NDIG; k++) digs_nxt[4*k +: 4] = {1'b0, m66[3*k +: 3]};
          state_nxt = ST_NORM;
        end else if (func_r == FN_CHR || func_r == FN_PCT) begin
          state_nxt = ST_SIZE;
        end else begin
          digs_nxt = {{(DIGW-64){1'b0}}, mag_r};
          state_nxt = ST_NORM;
        end
      end
      ST_CONV: begin
        if (!dab_busy) begin
          digs_nxt  = dab_bcd;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // strip one leading zero digit a cycle, keep at least one
        if (dl_r > 5'd1 && digs_r[DIGW-1 -: 4] == 4'd0) begin
          digs_nxt = {digs_r[DIGW-5:0], 4'd0};
          dl_nxt   = dl_r - 5'd1;
        end else begin
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        emit_start = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (dig_shift) digs_nxt = {digs_r[DIGW-5:0], 4'd0};
        if (!emit_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    func_r <= func_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    digs_r <= digs_nxt;
    dl_r   <= dl_nxt;
    if (accept) begin
      left_r  <= in_tdata[66];
      plus_r  <= in_tdata[67];
      space_r <= in_tdata[68];
      alt_r   <= in_tdata[69];
      zflag_r <= in_tdata[70];
      pg_r    <= in_tdata[77];
      width_r <= ({26'd0, f_width} > MAX_FIELD) ? 6'(MAX_FIELD) : f_width;
      prec_r  <= ({26'd0, f_prec} > MAX_FIELD) ? 6'(MAX_FIELD) : f_prec;
      chr_r   <= (in_tuser == FN_PCT) ? 8'h25 : f_value[7:0];
    end
  end

  ifmt_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dab_start),
    .bin   (mag_r),
    .busy  (dab_busy),
    .bcd   (dab_bcd)
  );

  ifmt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (emit_start),
    .plan       (plan),
    .dig        (digs_r[DIGW-1 -: 4]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .dig_shift  (dig_shift),
    .busy       (emit_busy)
  );

`ifndef SYNTHESIS
  a_emit_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    emit_busy |-> state_r == ST_EMIT) else $error("sequencer busy outside emit");
  a_dab_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    dab_busy |-> state_r == ST_CONV) else $error("converter busy outside conversion");
  a_norm_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NORM |-> dl_r != 5'd0) else $error("digit count empty while stripping");
`endif
endmodule

@@ src/ifmt_dabble.sv @@
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module ifmt_dabble (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [63:0]                bin,
  output logic                       busy,
  output logic [ifmt_pkg::DIGW-1:0]  bcd
);
  import ifmt_pkg::*;

  logic [63:0]     bin_r, bin_nxt;
  logic [DIGW-1:0] bcd_r, bcd_nxt, adj;
  logic [6:0]      cnt_r, cnt_nxt;

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      adj[4*k +: 4] = (bcd_r[4*k +: 4] >= 4'd5) ? bcd_r[4*k +: 4] + 4'd3 : bcd_r[4*k +: 4];
    end
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (start) begin
      bin_nxt = bin;
      bcd_nxt = '0;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      // adjust each digit, then shift the next bit in
      bcd_nxt = {adj[DIGW-2:0], bin_r[63]};
      bin_nxt = {bin_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 7'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign busy = cnt_r != 7'd0;
  assign bcd  = bcd_r;
endmodule

@@ src/ifmt_emit.sv @@
// Character sequencer: walks the field layout and drives the output word register.
module ifmt_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ifmt_pkg::plan_t plan,
  input  logic [3:0]      dig,
  input  logic            out_tready,
  output logic            out_tvalid,
  output logic [7:0]      out_tdata,   // [7:0] out_char
  output logic            out_tlast,
  output logic            dig_shift,
  output logic            busy
);
  import ifmt_pkg::*;

  plan_t      plan_r, plan_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic       busy_r, busy_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] od_r, od_nxt;
  logic       ol_r, ol_nxt;
  logic       adv, is_last;
  logic [7:0] ch;
  logic [6:0] nil_pos;

  assign adv     = busy_r && (!ov_r || out_tready);
  assign is_last = pos_r == plan_r.total - 7'd1;
  assign nil_pos = pos_r - plan_r.zero_end;

  always_comb begin
    dig_shift = 1'b0;
    if (pos_r < plan_r.pad_end) begin
      ch = 8'h20;
    end else if (pos_r < plan_r.pre_end) begin
      ch = (pos_r == plan_r.pad_end) ? plan_r.pre0 : plan_r.pre1;
    end else if (pos_r < plan_r.zero_end) begin
      ch = 8'h30;
    end else if (pos_r < plan_r.dig_end) begin
      case (plan_r.src)
        DS_NUM: begin
          ch = hex_char(dig, plan_r.upper);
          dig_shift = adv;
        end
        DS_NIL: ch = nil_char(nil_pos[2:0]);
        default: ch = plan_r.chr;
      endcase
    end else begin
      ch = 8'h20;
    end
  end

  always_comb begin
    plan_nxt = plan_r;
    pos_nxt  = pos_r;
    busy_nxt = busy_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    ol_nxt   = ol_r;
    if (start) begin
      plan_nxt = plan;
      pos_nxt  = 7'd0;
      busy_nxt = plan.total != 7'd0;
    end
    if (adv) begin
      ov_nxt  = 1'b1;
      od_nxt  = ch;
      ol_nxt  = is_last;
      pos_nxt = pos_r + 7'd1;
      if (is_last) busy_nxt = 1'b0;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    plan_r <= plan_nxt;
    pos_r  <= pos_nxt;
    od_r   <= od_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign busy       = busy_r;
endmodule

@@ sim/tb_integer_field_formatter_top.sv @@
// Self-checking testbench for the integer field formatter: stream driver, monitor, predictor.
`timescale 1ns / 100ps

module tb_integer_field_formatter_top;
  import ifmt_pkg::*;

  localparam int MAXF = 60;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [2:0]  func;
    logic [63:0] value;
    logic [1:0]  size_mod;
    logic        left_align;
    logic        force_sign;
    logic        space_sign;
    logic        alt_form;
    logic        zero_pad;
    logic [5:0]  field_width;
    logic        prec_given;
    logic [5:0]  prec_digits;
  } conv_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;   // [63:0] value, [65:64] size_mod, [66] left_align,
                           // [67] force_sign, [68] space_sign, [69] alt_form,
                           // [70] zero_pad, [76:71] field_width,
                           // [77] prec_given, [83:78] prec_digits, rest zero
  logic [2:0]  in_tuser;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_char
  logic        out_tlast;

  conv_req_t  pending_reqs[$];
  text_char_t expected_text[$];
  int errors;
  int mismatches;
  int cycles;
  int reqs_sent;
  int chars_seen;
  bit quiet_stretch;

  integer_field_formatter_top #(.MAX_FIELD(MAXF)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Build the expected text of one conversion and append it to the queue.
  task automatic predict_text(input conv_req_t r);
    byte unsigned pre[3];
    byte unsigned dig[64];
    byte unsigned rev[64];
    byte unsigned txt[$];
    int plen, dl, zeros, pad, wid, prc, k;
    bit zmode, use_prec;
    logic [63:0] mag, m;
    int unsigned base;
    bit upper;
    text_char_t tc;
    plen = 0; dl = 0; zeros = 0;
    wid = (r.field_width > MAXF) ? MAXF : r.field_width;
    prc = (r.prec_digits > MAXF) ? MAXF : r.prec_digits;
    zmode = r.zero_pad && !r.left_align && !r.prec_given;
    if (r.func <= FN_PTR) begin
      base = 10; upper = 0; use_prec = 1;
      if (r.func == FN_PTR) mag = r.value;
      else if (r.size_mod == SZ_16) begin
        mag = {48'd0, r.value[15:0]};
        if (r.func == FN_DEC && mag[15]) mag[63:16] = '1;
      end else if (r.size_mod == SZ_64) mag = r.value;
      else begin
        mag = {32'd0, r.value[31:0]};
        if (r.func == FN_DEC && mag[31]) mag[63:32] = '1;
      end
      if (r.func == FN_DEC) begin
        if (mag[63]) begin
          pre[plen++] = "-";
          mag = 64'd0 - mag;
        end else if (r.force_sign) pre[plen++] = "+";
        else if (r.space_sign) pre[plen++] = " ";
      end
      if (r.func == FN_OCT) base = 8;
      if (r.func >= FN_HEX) base = 16;
      if (r.func == FN_HEXU) upper = 1;
      if (r.func == FN_PTR) begin
        use_prec = 0;
        if (mag == 0) begin
          dig[0] = "("; dig[1] = "n"; dig[2] = "i"; dig[3] = "l"; dig[4] = ")";
          dl = 5; zmode = 0;
        end else begin
          pre[plen++] = "0"; pre[plen++] = "x";
        end
      end
      if (dl == 0 && !(use_prec && r.prec_given && prc == 0 && mag == 0)) begin
        m = mag;
        do begin
          k = int'(m % base);
          rev[dl++] = byte'((k < 10) ? (8'h30 + k) : ((upper ? 8'h37 : 8'h57) + k));
          m = m / base;
        end while (m != 0);
        for (k = 0; k < dl; k++) dig[k] = rev[dl - 1 - k];
      end
      if (use_prec && r.prec_given && prc > dl) zeros = prc - dl;
      if (r.alt_form && r.func == FN_OCT && zeros == 0 && (dl == 0 || dig[0] != "0"))
        pre[plen++] = "0";
      if (r.alt_form && (r.func == FN_HEX || r.func == FN_HEXU) && mag != 0) begin
        pre[plen++] = "0";
        pre[plen++] = upper ? "X" : "x";
      end
    end else begin
      dig[0] = (r.func == FN_CHR) ? r.value[7:0] : "%";
      dl = 1;
    end
    pad = wid - (plen + zeros + dl);
    if (pad < 0) pad = 0;
    if (zmode) begin
      zeros += pad; pad = 0;
    end
    if (!r.left_align) for (k = 0; k < pad; k++) txt.push_back(" ");
    for (k = 0; k < plen; k++) txt.push_back(pre[k]);
    for (k = 0; k < zeros; k++) txt.push_back("0");
    for (k = 0; k < dl; k++) txt.push_back(dig[k]);
    if (r.left_align) for (k = 0; k < pad; k++) txt.push_back(" ");
    for (k = 0; k < txt.size(); k++) begin
      tc.ch = txt[k];
      tc.last = (k == txt.size() - 1);
      expected_text.push_back(tc);
    end
  endtask

  function automatic conv_req_t plain_req(input logic [2:0] f, input logic [63:0] v,
                                          input logic [1:0] sz);
    conv_req_t r;
    r = '{default: '0};
    r.func = f; r.value = v; r.size_mod = sz;
    return r;
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = 64'd0;
      1: v = 64'($urandom_range(0, 20));
      2: v = {32'd0, $urandom};
      3: v = {$urandom, $urandom};
      4: v = {$urandom_range(0, 1) ? 32'hffffffff : 32'd0, $urandom};
      default: v = 64'h8000_0000_0000_0000 >> ($urandom_range(0, 3) * 16);
    endcase
    return v;
  endfunction

  // Fill the request queue: directed corners first, then random requests.
  initial begin
    conv_req_t r;
    int k;
    pending_reqs.push_back(plain_req(FN_DEC, 64'h8000_0000_0000_0000, SZ_64));
    pending_reqs.push_back(plain_req(FN_DEC, 64'h0000_0000_8000_0000, 2'd0));
    pending_reqs.push_back(plain_req(FN_DEC, 64'h0000_0000_0000_8000, SZ_16));
    pending_reqs.push_back(plain_req(FN_UNS, 64'hffff_ffff_ffff_ffff, SZ_64));
    pending_reqs.push_back(plain_req(FN_OCT, 64'hffff_ffff_ffff_ffff, SZ_64));
    pending_reqs.push_back(plain_req(FN_HEX, 64'hdead_beef_cafe_f00d, SZ_64));
    pending_reqs.push_back(plain_req(FN_HEXU, 64'h0123_4567_89ab_cdef, 2'd3));
    pending_reqs.push_back(plain_req(FN_PTR, 64'd0, 2'd0));
    pending_reqs.push_back(plain_req(FN_PTR, 64'hffff_ffff_ffff_ffff, SZ_16));
    pending_reqs.push_back(plain_req(FN_CHR, 64'h41, 2'd0));
    pending_reqs.push_back(plain_req(FN_PCT, 64'd0, 2'd0));
    // empty text: precision zero, value zero, width zero
    r = plain_req(FN_DEC, 64'd0, 2'd0); r.prec_given = 1; pending_reqs.push_back(r);
    // octal alternate form with value zero and precision zero
    r = plain_req(FN_OCT, 64'd0, 2'd0); r.prec_given = 1; r.alt_form = 1;
    pending_reqs.push_back(r);
    r = plain_req(FN_HEX, 64'd0, 2'd0); r.prec_given = 1; r.alt_form = 1;
    r.field_width = 6'd5; pending_reqs.push_back(r);
    // zero padding after sign and after 0x
    r = plain_req(FN_DEC, 64'hffff_ffff, 2'd0); r.zero_pad = 1; r.field_width = 6'd8;
    pending_reqs.push_back(r);
    r = plain_req(FN_HEX, 64'hab, 2'd0); r.zero_pad = 1; r.alt_form = 1; r.field_width = 6'd10;
    pending_reqs.push_back(r);
    r = plain_req(FN_PTR, 64'd0, 2'd0); r.zero_pad = 1; r.field_width = 6'd9;
    pending_reqs.push_back(r);
    // saturation of width and precision
    r = plain_req(FN_DEC, 64'd7, 2'd0); r.field_width = 6'd63; r.left_align = 1;
    r.force_sign = 1; pending_reqs.push_back(r);
    r = plain_req(FN_UNS, 64'd7, 2'd0); r.prec_given = 1; r.prec_digits = 6'd63;
    r.field_width = 6'd63; r.space_sign = 1; pending_reqs.push_back(r);
    r = plain_req(FN_DEC, 64'd5, 2'd0); r.space_sign = 1; r.force_sign = 1;
    pending_reqs.push_back(r);
    r = plain_req(FN_CHR, 64'hff, 2'd0); r.zero_pad = 1; r.field_width = 6'd4;
    r.force_sign = 1; pending_reqs.push_back(r);
    r = plain_req(FN_OCT, 64'd8, 2'd0); r.alt_form = 1; r.prec_given = 1;
    r.prec_digits = 6'd5; pending_reqs.push_back(r);
    for (k = 0; k < 308; k++) begin
      r.func = 3'($urandom_range(0, 7));
      r.value = rand_value();
      r.size_mod = 2'($urandom_range(0, 3));
      r.left_align = 1'($urandom_range(0, 1));
      r.force_sign = 1'($urandom_range(0, 1));
      r.space_sign = 1'($urandom_range(0, 1));
      r.alt_form = 1'($urandom_range(0, 1));
      r.zero_pad = 1'($urandom_range(0, 1));
      // mostly modest widths, a few near or beyond the saturation point
      r.field_width = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(56, 63)
                                                      : $urandom_range(0, 24));
      r.prec_given = 1'($urandom_range(0, 1));
      r.prec_digits = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(56, 63)
                                                      : $urandom_range(0, 24));
      pending_reqs.push_back(r);
    end
  end

  // Quiet stretch: no idling on either side for a while mid-run.
  always @(posedge clk) quiet_stretch <= (cycles > 12000 && cycles < 20000);

  // Driver: present the oldest pending request, advance on handshake.
  always @(posedge clk) begin
    conv_req_t r;
    bit show;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_text(pending_reqs.pop_front());
        reqs_sent++;
      end
      if (!in_tvalid || in_tready) begin
        show = (pending_reqs.size() > 0) && (quiet_stretch || $urandom_range(0, 99) >= 12);
        if (show && !(in_tvalid && in_tready && pending_reqs.size() == 0)) begin
          r = pending_reqs[0];
          in_tvalid <= 1'b1;
          in_tuser <= r.func;
          in_tdata <= {4'd0, r.prec_digits, r.prec_given, r.field_width, r.zero_pad,
                       r.alt_form, r.space_sign, r.force_sign, r.left_align, r.size_mod,
                       r.value};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted character with the oldest expectation.
  always @(posedge clk) begin
    text_char_t e;
    cycles++;
    if (rst_n) begin
      out_tready <= quiet_stretch || ($urandom_range(0, 99) >= 12);
      if (out_tvalid && out_tready) begin
        chars_seen++;
        if (expected_text.size() == 0) begin
          errors++;
          if (mismatches++ < 10)
            $display("unexpected word: char %h last %b", out_tdata, out_tlast);
        end else begin
          e = expected_text.pop_front();
          if (e.ch !== out_tdata || e.last !== out_tlast) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: expected char %h last %b, got char %h last %b",
                       e.ch, e.last, out_tdata, out_tlast);
          end
        end
      end
    end
  end

  initial begin
    errors = 0; mismatches = 0; cycles = 0; reqs_sent = 0; chars_seen = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0; out_tready = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // hold until all requests are in and drained, bounded by the cycle limit
    while ((pending_reqs.size() > 0 || in_tvalid || expected_text.size() > 0)
           && cycles < LIMIT_CYCLES)
      @(posedge clk);
    if (cycles >= LIMIT_CYCLES) begin
      $display("[integer_field_formatter_top] ERROR");
      $finish;
    end else begin
      repeat (200) @(posedge clk);
      $display("covered %0d conversion requests of every kind, %0d characters checked",
               reqs_sent, chars_seen);
      if (errors == 0) begin
        $display("[integer_field_formatter_top] OK");
      end else begin
        $display("%0d mismatches", errors);
        $display("[integer_field_formatter_top] ERROR");
      end
      $finish;
    end
  end

endmodule

@@ filelist.f @@
src/ifmt_pkg.sv
src/ifmt_dabble.sv
src/ifmt_emit.sv
src/integer_field_formatter_top.sv
sim/tb_integer_field_formatter_top.sv
